// ===== rtl/core/epoch_resync_report_queue_macros.svh =====
// Assertion macros for the report queue
`ifndef EPOCH_RESYNC_REPORT_QUEUE_MACROS_SVH
`define EPOCH_RESYNC_REPORT_QUEUE_MACROS_SVH

`ifndef SYNTH
`define ERQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ERQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ERQ_ASSERT_IMPL(label, ante, cons, msg)
`define ERQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/erq_pkg.sv =====
`default_nettype none
package erq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = CNT_W + 1;

	localparam logic [2:0] ACT_PUBLISH   = 3'd0;
	localparam logic [2:0] ACT_SRC_RESET = 3'd1;
	localparam logic [2:0] ACT_RESYNC    = 3'd2;
	localparam logic [2:0] ACT_SET_ACT   = 3'd3;
	localparam logic [2:0] ACT_POP       = 3'd4;
	localparam logic [2:0] ACT_ACK       = 3'd5;
	localparam logic [2:0] ACT_TAKE_WAKE = 3'd6;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] key_state;
		logic [31:0] epoch;
		logic        active_flag;
	} erq_cmd_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] item_state;
		logic [31:0] item_epoch;
		logic [31:0] item_sequence;
		logic        wake_req;
		logic [63:0] latest_state;
		logic [3:0]  queue_count;
		logic [31:0] stale_count;
		logic [31:0] ovf_total;
	} erq_rsp_t;

	typedef struct packed {
		logic [63:0] keys;
		logic [31:0] epoch;
		logic [31:0] seq;
	} erq_entry_t;

	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] slot;
		erq_entry_t       entry;
	} erq_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/erq_store.sv =====
`default_nettype none
module erq_store (
	input  wire logic                    clk,
	input  wire erq_pkg::erq_wr_t        wr_a,
	input  wire erq_pkg::erq_wr_t        wr_b,
	input  wire logic [erq_pkg::PTR_W-1:0] rd_slot,
	output erq_pkg::erq_entry_t          rd_entry
);
	import erq_pkg::*;

	erq_entry_t entries_q [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_a.en) begin
			entries_q[wr_a.slot] <= wr_a.entry;
		end
		if (wr_b.en) begin
			entries_q[wr_b.slot] <= wr_b.entry;
		end
	end

	assign rd_entry = entries_q[rd_slot];

endmodule
`default_nettype wire

// ===== rtl/core/erq_ctrl.sv =====
`default_nettype none
module erq_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      vld,
	input  wire erq_pkg::erq_cmd_t         cmd,
	input  wire erq_pkg::erq_entry_t       rd_entry,
	output logic [erq_pkg::PTR_W-1:0]      rd_slot,
	output erq_pkg::erq_wr_t               wr_a,
	output erq_pkg::erq_wr_t               wr_b,
	output erq_pkg::erq_rsp_t              rsp_d
);
	import erq_pkg::*;

	logic [PTR_W-1:0] rp_q, n_rp;
	logic [CNT_W-1:0] cnt_q, n_cnt;
	logic [31:0]      ep_q, n_ep;
	logic [63:0]      last_q, n_last;
	logic             wake_q, n_wake;
	logic             act_q, n_act;
	logic [31:0]      seq_q, n_seq;
	logic [31:0]      stale_q, n_stale;
	logic [31:0]      ovf_q, n_ovf;

	logic             do_resync, app_a, app_b, restart, ok;
	logic [63:0]      rs_keys;
	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail_slot;
	erq_entry_t       item;

	assign rd_slot   = rp_q;
	assign tail_sum  = SUM_W'(rp_q) + SUM_W'(cnt_q);
	assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

	always_comb begin
		n_rp      = rp_q;
		n_cnt     = cnt_q;
		n_ep      = ep_q;
		n_last    = last_q;
		n_wake    = wake_q;
		n_act     = act_q;
		n_seq     = seq_q;
		n_stale   = stale_q;
		n_ovf     = ovf_q;
		do_resync = 1'b0;
		app_a     = 1'b0;
		app_b     = 1'b0;
		rs_keys   = last_q;
		ok        = 1'b0;
		item      = '0;
		restart   = 1'b0;
		wr_a      = '0;
		wr_b      = '0;

		unique case (cmd.action)
			ACT_PUBLISH: begin
				if (cmd.epoch < ep_q) begin
					n_stale = stale_q + 32'd1;
				end else begin
					restart = cmd.epoch > ep_q;
					if (restart) begin
						n_ep      = cmd.epoch;
						n_last    = '0;
						n_wake    = 1'b0;
						n_rp      = '0;
						n_cnt     = '0;
						do_resync = act_q;
						rs_keys   = '0;
					end
					if (cmd.key_state != n_last) begin
						if (|(cmd.key_state & ~n_last)) begin
							n_wake = 1'b1;
						end
						n_last = cmd.key_state;
						if (act_q) begin
							priority if (restart) begin
								app_b = 1'b1;
							end else if (cnt_q >= CNT_W'(QUEUE_DEPTH)) begin
								n_ovf     = ovf_q + 32'd1;
								do_resync = 1'b1;
								rs_keys   = cmd.key_state;
							end else begin
								app_a = 1'b1;
							end
						end
					end
				end
			end
			ACT_SRC_RESET: begin
				if (cmd.epoch < ep_q) begin
					n_stale = stale_q + 32'd1;
				end else begin
					n_ep      = cmd.epoch;
					n_last    = '0;
					n_wake    = 1'b0;
					n_rp      = '0;
					n_cnt     = '0;
					do_resync = act_q;
					rs_keys   = '0;
				end
			end
			ACT_RESYNC: begin
				do_resync = act_q;
			end
			ACT_SET_ACT: begin
				if (act_q != cmd.active_flag) begin
					n_act     = cmd.active_flag;
					n_rp      = '0;
					n_cnt     = '0;
					do_resync = cmd.active_flag;
				end
			end
			ACT_POP: begin
				if (cnt_q != '0) begin
					ok    = 1'b1;
					item  = rd_entry;
					n_rp  = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
					n_cnt = cnt_q - CNT_W'(1);
				end
			end
			ACT_ACK: begin
				if (wake_q && cnt_q == '0 && cmd.epoch == ep_q &&
				    cmd.key_state == last_q) begin
					n_wake = 1'b0;
					ok     = 1'b1;
				end
			end
			ACT_TAKE_WAKE: begin
				ok     = wake_q;
				n_wake = 1'b0;
			end
			default: begin
			end
		endcase

		// rebuild queue: released entry, then held keys if any
		if (do_resync) begin
			n_rp             = '0;
			wr_a.en          = 1'b1;
			wr_a.slot        = '0;
			wr_a.entry.keys  = '0;
			wr_a.entry.epoch = n_ep;
			wr_a.entry.seq   = seq_q;
			if (rs_keys != '0) begin
				wr_b.en          = 1'b1;
				wr_b.slot        = PTR_W'(1);
				wr_b.entry.keys  = rs_keys;
				wr_b.entry.epoch = n_ep;
				wr_b.entry.seq   = seq_q + 32'd1;
				n_cnt            = CNT_W'(2);
				n_seq            = seq_q + 32'd2;
			end else begin
				n_cnt = CNT_W'(1);
				n_seq = seq_q + 32'd1;
			end
		end
		if (app_b) begin
			wr_b.en          = 1'b1;
			wr_b.slot        = PTR_W'(1);
			wr_b.entry.keys  = cmd.key_state;
			wr_b.entry.epoch = n_ep;
			wr_b.entry.seq   = seq_q + 32'd1;
			n_cnt            = CNT_W'(2);
			n_seq            = seq_q + 32'd2;
		end
		if (app_a) begin
			wr_a.en          = 1'b1;
			wr_a.slot        = tail_slot;
			wr_a.entry.keys  = cmd.key_state;
			wr_a.entry.epoch = n_ep;
			wr_a.entry.seq   = seq_q;
			n_cnt            = cnt_q + CNT_W'(1);
			n_seq            = seq_q + 32'd1;
		end

		wr_a.en = wr_a.en & vld;
		wr_b.en = wr_b.en & vld;

		rsp_d.ok             = ok;
		rsp_d.item_state     = item.keys;
		rsp_d.item_epoch     = item.epoch;
		rsp_d.item_sequence  = item.seq;
		rsp_d.wake_req       = n_wake;
		rsp_d.latest_state   = n_last;
		rsp_d.queue_count    = 4'(n_cnt);
		rsp_d.stale_count    = n_stale;
		rsp_d.ovf_total      = n_ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			cnt_q   <= '0;
			ep_q    <= '0;
			last_q  <= '0;
			wake_q  <= 1'b0;
			act_q   <= 1'b0;
			seq_q   <= 32'd1;
			stale_q <= '0;
			ovf_q   <= '0;
		end else if (vld) begin
			rp_q    <= n_rp;
			cnt_q   <= n_cnt;
			ep_q    <= n_ep;
			last_q  <= n_last;
			wake_q  <= n_wake;
			act_q   <= n_act;
			seq_q   <= n_seq;
			stale_q <= n_stale;
			ovf_q   <= n_ovf;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/epoch_resync_report_queue.sv =====
// Ring queue of keyboard-state reports stamped with epoch and sequence.
// Command channel: cmd is taken at a rising edge with start high and busy
// low. busy stays low: a command is taken in every cycle.
// Result channel: one result per command, shown on rsp for exactly one cycle
// with done high. The receiver cannot stall; results must be taken as shown.
// Path: the accepting edge loads the input register; decode and state update
// are combinational into the result register, whose loading edge raises done.
// Throughput: one command per cycle, as the state update between the input
// and result registers is combinational.
// Each command updates the queue and counters once; a resync or an epoch
// restart writes up to two entries in the same cycle.
// Reset (arst_n low) empties the queue, clears epoch, held keys, wake and
// host-active flags and both counters, and sets the sequence counter to one.
`default_nettype none
`include "epoch_resync_report_queue_macros.svh"
module epoch_resync_report_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire erq_pkg::erq_cmd_t cmd,
	output logic                   done,
	output erq_pkg::erq_rsp_t      rsp
);
	import erq_pkg::*;

	logic             valid_s1;
	erq_cmd_t         cmd_s1;
	erq_rsp_t         rsp_d;
	erq_entry_t       rd_entry;
	erq_wr_t          wr_a, wr_b;
	logic [PTR_W-1:0] rd_slot;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			rsp <= rsp_d;
		end
	end

	erq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (valid_s1),
		.cmd      (cmd_s1),
		.rd_entry (rd_entry),
		.rd_slot  (rd_slot),
		.wr_a     (wr_a),
		.wr_b     (wr_b),
		.rsp_d    (rsp_d)
	);

	erq_store u_store (
		.clk      (clk),
		.wr_a     (wr_a),
		.wr_b     (wr_b),
		.rd_slot  (rd_slot),
		.rd_entry (rd_entry)
	);

	`ERQ_ASSERT_IMPL(a_done_follows_start, done, $past(start && !busy, 2), "result without command")
	`ERQ_ASSERT_IMPL(a_count_bound, done, rsp.queue_count <= 4'(QUEUE_DEPTH), "queue count over depth")
	`ERQ_ASSERT_IMPL(a_item_zero, done && !rsp.ok, rsp.item_state == '0 && rsp.item_sequence == '0, "item set without ok")
	`ERQ_ASSERT_NEXT(a_dual_write_slots, wr_a.en && wr_b.en, $past(wr_a.slot) != $past(wr_b.slot), "write slot clash")

endmodule
`default_nettype wire
